### design/rfb_pkg.sv
// ----------------------------------------------------------------------------
// rfb_pkg
// Shared types, constants and the CRC step for the RFID command frame builder.
// ----------------------------------------------------------------------------
package rfb_pkg;

  // request queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // frame constants
  localparam logic [7:0]  ADDR_ALL  = 8'hff;
  localparam logic [7:0]  LEN_WRITE = 8'h0a;
  localparam logic [7:0]  CMD_WRITE = 8'h10;
  localparam logic [7:0]  LEN_READ  = 8'h06;
  localparam logic [7:0]  CMD_READ  = 8'h12;
  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [15:0] CRC_TOP   = 16'h8000;

  // byte positions inside a frame
  typedef logic [3:0] idx_t;
  localparam idx_t IDX_ADDR   = 4'd0;
  localparam idx_t IDX_LEN    = 4'd1;
  localparam idx_t IDX_CMD    = 4'd2;
  localparam idx_t IDX_PL3    = 4'd3;
  localparam idx_t IDX_PL2    = 4'd4;
  localparam idx_t IDX_PL1    = 4'd5;
  localparam idx_t IDX_PL0    = 4'd6;
  localparam idx_t IDX_W_SEC  = 4'd7;
  localparam idx_t IDX_W_CRCH = 4'd8;
  localparam idx_t IDX_W_CRCL = 4'd9;
  localparam idx_t IDX_R_SEC  = 4'd3;
  localparam idx_t IDX_R_CRCH = 4'd4;
  localparam idx_t IDX_R_CRCL = 4'd5;

  // one classified request as queued
  typedef struct packed {
    logic        is_write;
    logic [31:0] payload;
    logic [7:0]  sector;
    logic [7:0]  addr;
  } req_t;

  // queue status toward the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // CRC-16 (poly 0x1021) update by one byte, MSB first
  function automatic logic [15:0] crc_add_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = {crc[15:8] ^ b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c ^ {crc[7:0], 8'h00};
  endfunction

endpackage

### design/rfb_front.sv
// ----------------------------------------------------------------------------
// rfb_front
// Holds the module address register, accepts requests and queues them.
// ----------------------------------------------------------------------------
module rfb_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [39:0]        in_tdata,
  input  logic               in_tuser,
  input  rfb_pkg::qstat_t    q_stat,
  output logic               q_push,
  output rfb_pkg::req_t      q_wdata
);
  import rfb_pkg::*;

  logic [7:0] addr_r;
  logic [7:0] addr_nxt;

  // module address register
  always_comb begin
    addr_nxt = addr_r;
    if (cfg_we) begin
      addr_nxt = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= ADDR_ALL;
    end else begin
      addr_r <= addr_nxt;
    end
  end

  // accept while the queue has room
  assign in_tready = !q_stat.full;
  assign q_push    = in_tvalid && in_tready;

  // classify and tag with the current address
  assign q_wdata.is_write = in_tuser;
  assign q_wdata.payload  = in_tdata[31:0];
  assign q_wdata.sector   = in_tdata[39:32];
  assign q_wdata.addr     = addr_r;

endmodule

### design/rfb_queue.sv
// ----------------------------------------------------------------------------
// rfb_queue
// Small request queue decoupling the front from the frame serializer.
// ----------------------------------------------------------------------------
module rfb_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rfb_pkg::req_t      wdata,
  input  logic               pop,
  output rfb_pkg::req_t      rdata,
  output rfb_pkg::qstat_t    stat
);
  import rfb_pkg::*;

  req_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

### design/rfb_back.sv
// ----------------------------------------------------------------------------
// rfb_back
// Serializes the queue head into frame bytes with a running CRC.
// ----------------------------------------------------------------------------
module rfb_back (
  input  logic               clk,
  input  logic               rst_n,
  input  rfb_pkg::req_t      q_rdata,
  input  rfb_pkg::qstat_t    q_stat,
  output logic               q_pop,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [7:0]         out_tdata,
  output logic               out_tlast
);
  import rfb_pkg::*;

  idx_t        idx_r, idx_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        valid_r, valid_nxt;
  logic [7:0]  data_r, data_nxt;
  logic        last_r, last_nxt;

  logic        advance;
  logic [7:0]  byte_sel;
  logic        is_last;
  logic        is_crc;
  logic [15:0] crc_base;

  // one byte per cycle while a request is queued and the output register is free
  assign advance = !q_stat.empty && (!valid_r || out_tready);

  // byte of the current position
  always_comb begin
    byte_sel = 8'h00;
    is_last  = 1'b0;
    is_crc   = 1'b0;
    if (q_rdata.is_write) begin
      case (idx_r)
        IDX_ADDR:   byte_sel = q_rdata.addr;
        IDX_LEN:    byte_sel = LEN_WRITE;
        IDX_CMD:    byte_sel = CMD_WRITE;
        IDX_PL3:    byte_sel = q_rdata.payload[31:24];
        IDX_PL2:    byte_sel = q_rdata.payload[23:16];
        IDX_PL1:    byte_sel = q_rdata.payload[15:8];
        IDX_PL0:    byte_sel = q_rdata.payload[7:0];
        IDX_W_SEC:  byte_sel = q_rdata.sector;
        IDX_W_CRCH: begin
          byte_sel = crc_r[15:8];
          is_crc   = 1'b1;
        end
        IDX_W_CRCL: begin
          byte_sel = crc_r[7:0];
          is_crc   = 1'b1;
          is_last  = 1'b1;
        end
        default: byte_sel = 8'h00;
      endcase
    end else begin
      case (idx_r)
        IDX_ADDR:   byte_sel = q_rdata.addr;
        IDX_LEN:    byte_sel = LEN_READ;
        IDX_CMD:    byte_sel = CMD_READ;
        IDX_R_SEC:  byte_sel = q_rdata.sector;
        IDX_R_CRCH: begin
          byte_sel = crc_r[15:8];
          is_crc   = 1'b1;
        end
        IDX_R_CRCL: begin
          byte_sel = crc_r[7:0];
          is_crc   = 1'b1;
          is_last  = 1'b1;
        end
        default: byte_sel = 8'h00;
      endcase
    end
  end

  // CRC restarts at the first byte of each frame
  assign crc_base = (idx_r == IDX_ADDR) ? 16'h0000 : crc_r;
  assign q_pop    = advance && is_last;

  // sequencer and output register
  always_comb begin
    idx_nxt   = idx_r;
    crc_nxt   = crc_r;
    valid_nxt = valid_r;
    data_nxt  = data_r;
    last_nxt  = last_r;
    if (advance) begin
      idx_nxt   = is_last ? IDX_ADDR : idx_r + 1'b1;
      if (!is_crc) begin
        crc_nxt = crc_add_byte(crc_base, byte_sel);
      end
      valid_nxt = 1'b1;
      data_nxt  = byte_sel;
      last_nxt  = is_last;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= IDX_ADDR;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
    crc_r  <= crc_nxt;
    data_r <= data_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;

endmodule

### design/rfid_command_frame_builder.sv
// ----------------------------------------------------------------------------
// rfid_command_frame_builder
// Builds CRC-16 framed sector read/write commands for an RFID module.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one command request per item. in_tuser selects sector read (0)
//           or sector write (1); in_tdata carries payload and sector.
//   out_* : the command frame, one byte per item, out_tlast on the CRC low byte.
//           Read frames are 6 bytes, write frames are 10 bytes.
//   cfg_* : cfg_we writes the module address used as the first frame byte.
// Path: an accepted request is written into the request queue at the accepting
//   edge, and its first frame byte then passes through the byte output register.
// Throughput: one byte per cycle while out_tready is high and a request is
//   queued; set by the single byte serializer and its output register.
//   A two-entry request queue lets new requests be taken while a frame is sent.
// Reset: queue empty, serializer at the frame start, address 0xff (broadcast).
// Stall: when out_tready is low the output byte holds, the serializer waits,
//   and in_tready drops once the request queue is full.
// ----------------------------------------------------------------------------
module rfid_command_frame_builder (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,    // module_address
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,     // [31:0] payload, [39:32] sector
  input  logic        in_tuser,     // [0] func
  // frame byte channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,    // [7:0] frame_byte
  output logic        out_tlast     // last_byte
);
  import rfb_pkg::*;

  req_t   q_wdata;
  req_t   q_rdata;
  qstat_t q_stat;
  logic   q_push;
  logic   q_pop;

  // request intake and address register
  rfb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  // request queue
  rfb_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // frame serializer
  rfb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_rdata    (q_rdata),
    .q_stat     (q_stat),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
